// File: design/bvm_pkg.sv
// Shared types and constants of the battery voltage monitor.
// Used by the controller, the datapath and the top level.
package bvm_pkg;

    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_W       = 24;
    localparam int OUT_W      = 48;
    localparam int PIN_FULL_W = 28;
    localparam int DIV_W      = PIN_FULL_W + CFG_W;

    localparam logic [CFG_W-1:0] GAIN_NUM_RST = 16'd1532;
    localparam logic [CFG_W-1:0] GAIN_DEN_RST = 16'd1580;
    localparam logic [CFG_W-1:0] DIV_NUM_RST  = 16'd3810;
    localparam logic [CFG_W-1:0] DIV_DEN_RST  = 16'd1480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_NUM = 3'd0,
        CFG_GAIN_DEN = 3'd1,
        CFG_DIV_NUM  = 3'd2,
        CFG_DIV_DEN  = 3'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_CODE = 2'd0,
        OP_MV   = 2'd1,
        OP_PIN  = 2'd2,
        OP_BAT  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_CODE,
        ST_MV,
        ST_MUL_PIN,
        ST_PIN,
        ST_PIN_W,
        ST_MUL_BAT,
        ST_BAT,
        ST_BAT_W,
        ST_EMIT,
        ST_CHARGE
    } t_state;

    typedef struct packed {
        logic acc;
        logic div_start;
        logic div_cap;
        logic mul_en;
        logic ema_en;
        logic out_ld;
        t_op  sel;
    } t_cmd;

    typedef struct packed {
        logic last_item;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// File: design/bvm_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on bvm_pkg for the dividend and divisor widths.
module bvm_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bvm_pkg::DIV_W-1:0]  i_dividend,
    input  logic [bvm_pkg::CFG_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [bvm_pkg::DIV_W-1:0]  o_quotient
);
    import bvm_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CFG_W-1:0] r_rem, n_rem;
    logic [CFG_W-1:0] r_dsr, n_dsr;
    logic [DIV_W-1:0] r_quo, n_quo;
    logic [CFG_W:0]   w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIV_W);
            n_rem  = '0;
            n_dsr  = i_divisor;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            n_rem = w_ge ? CFG_W'(w_trial - {1'b0, r_dsr}) : w_trial[CFG_W-1:0];
            n_quo = {r_quo[DIV_W-2:0], w_ge};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dsr <= n_dsr;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: design/bvm_ctrl.sv
// Controller state machine: burst collection and the post-burst sequence.
// Depends on bvm_pkg for the state, command and status types.
module bvm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  bvm_pkg::t_sts i_sts,
    output bvm_pkg::t_cmd o_cmd
);
    import bvm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCUM;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.sel       = OP_CODE;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            ST_ACCUM: begin
                o_s_axis_tready = 1'b1;
                o_cmd.acc       = i_s_axis_tvalid;
                if (i_s_axis_tvalid && i_sts.last_item) begin
                    n_state = ST_CODE;
                end
            end
            ST_CODE: begin
                o_cmd.div_cap = 1'b1;
                n_state       = ST_MV;
            end
            ST_MV: begin
                o_cmd.sel     = OP_MV;
                o_cmd.div_cap = 1'b1;
                n_state       = ST_MUL_PIN;
            end
            ST_MUL_PIN: begin
                o_cmd.sel    = OP_PIN;
                o_cmd.mul_en = 1'b1;
                n_state      = ST_PIN;
            end
            ST_PIN: begin
                o_cmd.sel       = OP_PIN;
                o_cmd.div_start = 1'b1;
                n_state         = ST_PIN_W;
            end
            ST_PIN_W: begin
                o_cmd.sel = OP_PIN;
                if (i_sts.div_done) begin
                    o_cmd.div_cap = 1'b1;
                    n_state       = ST_MUL_BAT;
                end
            end
            ST_MUL_BAT: begin
                o_cmd.sel    = OP_BAT;
                o_cmd.mul_en = 1'b1;
                n_state      = ST_BAT;
            end
            ST_BAT: begin
                o_cmd.sel       = OP_BAT;
                o_cmd.div_start = 1'b1;
                n_state         = ST_BAT_W;
            end
            ST_BAT_W: begin
                o_cmd.sel = OP_BAT;
                if (i_sts.div_done) begin
                    o_cmd.div_cap = 1'b1;
                    n_state       = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.ema_en = 1'b1;
                    n_state      = ST_CHARGE;
                end
            end
            ST_CHARGE: begin
                o_cmd.out_ld = 1'b1;
                n_state      = ST_ACCUM;
            end
            default: begin
                n_state = ST_ACCUM;
            end
        endcase
    end

endmodule

// File: design/bvm_datapath.sv
// Datapath: burst sums and extremes, calibration multiplier, filters, output register.
// Depends on bvm_pkg and instantiates the serial divider bvm_div.
module bvm_datapath #(
    parameter int SAMPLES  = 16,
    parameter int ADC_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bvm_pkg::t_cmd                 i_cmd,
    output bvm_pkg::t_sts                 o_sts,
    input  logic [bvm_pkg::IN_W-1:0]      i_tdata,
    input  logic                          i_cfg_we,
    input  logic [bvm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bvm_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [bvm_pkg::OUT_W-1:0]     o_m_tdata
);
    import bvm_pkg::*;

    localparam int IDX_W = $clog2(SAMPLES);
    localparam int SUM_W = 12 + $clog2(SAMPLES);
    localparam logic [11:0] CODE_MASK =
        (ADC_BITS >= 12) ? 12'hFFF : 12'((1 << ADC_BITS) - 1);
    // floor(x / (SAMPLES-2)) as (x * MEAN_M) >> MEAN_SH, exact for every x of SUM_W bits
    localparam int MEAN_D      = SAMPLES - 2;
    localparam int MEAN_SH     = SUM_W + $clog2(MEAN_D);
    localparam int MEAN_PROD_W = SUM_W + MEAN_SH;
    localparam longint MEAN_M_L =
        ((longint'(1) << MEAN_SH) + longint'(MEAN_D) - 1) / longint'(MEAN_D);
    localparam logic [MEAN_SH-1:0] MEAN_M = MEAN_SH'(MEAN_M_L);

    function automatic logic [15:0] ema4(input logic [15:0] old_v, input logic [15:0] new_v);
        logic [17:0] s;
        begin
            s = 18'(old_v) * 18'd3 + 18'(new_v);
            ema4 = s[17:2];
        end
    endfunction

    function automatic logic [6:0] charge_pct(input logic [15:0] v);
        logic [15:0] d;
        logic [10:0] x;
        logic [24:0] p;
        logic [6:0]  q;
        begin
            d = '0;
            x = '0;
            p = '0;
            q = '0;
            if (v >= 16'd4200) begin
                q = 7'd100;
            end else if (v >= 16'd4000) begin
                d = v - 16'd4000;
                p = 25'(d[7:0]) * 25'd205;
                q = 7'd80 + 7'(p >> 11);
            end else if (v >= 16'd3800) begin
                d = v - 16'd3800;
                q = 7'd55 + 7'(d[7:0] >> 3);
            end else if (v >= 16'd3700) begin
                d = v - 16'd3700;
                x = 11'(d[6:0]) * 11'd15;
                p = 25'(x) * 25'd5243;
                q = 7'd40 + 7'(p >> 19);
            end else if (v >= 16'd3600) begin
                d = v - 16'd3600;
                x = 11'(d[6:0]) * 11'd15;
                p = 25'(x) * 25'd5243;
                q = 7'd25 + 7'(p >> 19);
            end else if (v >= 16'd3500) begin
                d = v - 16'd3500;
                x = 11'(d[6:0]) * 11'd13;
                p = 25'(x) * 25'd5243;
                q = 7'd12 + 7'(p >> 19);
            end else if (v >= 16'd3300) begin
                d = v - 16'd3300;
                x = 11'(d[7:0]) * 11'd3;
                p = 25'(x) * 25'd5243;
                q = 7'(p >> 18);
            end
            charge_pct = q;
        end
    endfunction

    logic [CFG_W-1:0]      r_gain_num, r_gain_den, r_div_num, r_div_den;
    logic [IDX_W-1:0]      r_idx;
    logic [SUM_W-1:0]      r_code_sum, r_mv_sum;
    logic [11:0]           r_code_lo, r_code_hi, r_mv_lo, r_mv_hi;
    logic [11:0]           r_code_mean, r_mv_mean;
    logic [PIN_FULL_W-1:0] r_pin_full;
    logic [15:0]           r_bat_new;
    logic [DIV_W-1:0]      r_prod;
    logic                  r_loaded;
    logic [11:0]           r_filt_code, r_filt_pin;
    logic [15:0]           r_filt_bat;
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;

    logic [11:0]           w_code, w_mv, w_new_pin;
    logic                  w_last;
    logic [SUM_W-1:0]      w_code_trim, w_mv_trim, w_trim;
    logic [MEAN_PROD_W-1:0] w_mean_prod;
    logic [11:0]           w_mean;
    logic [DIV_W-1:0]      w_dividend, w_quo;
    logic [CFG_W-1:0]      w_divisor, w_gden, w_dden, w_mul_b;
    logic [PIN_FULL_W-1:0] w_mul_a;
    logic                  w_div_done;
    logic [15:0]           w_ema_code, w_ema_pin, w_ema_bat;

    assign w_code      = i_tdata[11:0] & CODE_MASK;
    assign w_mv        = i_tdata[23:12];
    assign w_last      = r_idx == IDX_W'(SAMPLES - 1);
    assign w_code_trim = r_code_sum - SUM_W'(r_code_lo) - SUM_W'(r_code_hi);
    assign w_mv_trim   = r_mv_sum - SUM_W'(r_mv_lo) - SUM_W'(r_mv_hi);
    assign w_trim      = (i_cmd.sel == OP_MV) ? w_mv_trim : w_code_trim;
    assign w_mean_prod = MEAN_PROD_W'(w_trim) * MEAN_PROD_W'(MEAN_M);
    assign w_mean      = w_mean_prod[MEAN_SH +: 12];
    assign w_gden      = (r_gain_den == '0) ? CFG_W'(1) : r_gain_den;
    assign w_dden      = (r_div_den == '0) ? CFG_W'(1) : r_div_den;
    assign w_new_pin   = (|r_pin_full[PIN_FULL_W-1:12]) ? 12'hFFF : r_pin_full[11:0];
    assign w_ema_code  = ema4({4'd0, r_filt_code}, {4'd0, r_code_mean});
    assign w_ema_pin   = ema4({4'd0, r_filt_pin}, {4'd0, w_new_pin});
    assign w_ema_bat   = ema4(r_filt_bat, r_bat_new);

    always_comb begin
        w_dividend = r_prod;
        if (i_cmd.sel == OP_PIN) begin
            w_divisor = w_gden;
            w_mul_a   = PIN_FULL_W'(r_mv_mean);
            w_mul_b   = r_gain_num;
        end else begin
            w_divisor = w_dden;
            w_mul_a   = r_pin_full;
            w_mul_b   = r_div_num;
        end
    end

    bvm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_num <= GAIN_NUM_RST;
            r_gain_den <= GAIN_DEN_RST;
            r_div_num  <= DIV_NUM_RST;
            r_div_den  <= DIV_DEN_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_NUM: r_gain_num <= i_cfg_data;
                CFG_GAIN_DEN: r_gain_den <= i_cfg_data;
                CFG_DIV_NUM:  r_div_num  <= i_cfg_data;
                CFG_DIV_DEN:  r_div_den  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_code_sum <= '0;
            r_mv_sum   <= '0;
            r_code_lo  <= 12'hFFF;
            r_code_hi  <= '0;
            r_mv_lo    <= 12'hFFF;
            r_mv_hi    <= '0;
        end else if (i_cmd.acc) begin
            r_idx      <= w_last ? '0 : r_idx + IDX_W'(1);
            r_code_sum <= r_code_sum + SUM_W'(w_code);
            r_mv_sum   <= r_mv_sum + SUM_W'(w_mv);
            if (w_code < r_code_lo) r_code_lo <= w_code;
            if (w_code > r_code_hi) r_code_hi <= w_code;
            if (w_mv < r_mv_lo) r_mv_lo <= w_mv;
            if (w_mv > r_mv_hi) r_mv_hi <= w_mv;
        end else if (i_cmd.out_ld) begin
            r_code_sum <= '0;
            r_mv_sum   <= '0;
            r_code_lo  <= 12'hFFF;
            r_code_hi  <= '0;
            r_mv_lo    <= 12'hFFF;
            r_mv_hi    <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= DIV_W'(w_mul_a) * DIV_W'(w_mul_b);
        end
        if (i_cmd.div_cap) begin
            case (i_cmd.sel)
                OP_CODE: r_code_mean <= w_mean;
                OP_MV:   r_mv_mean   <= w_mean;
                OP_PIN:  r_pin_full  <= w_quo[PIN_FULL_W-1:0];
                default: r_bat_new   <= (|w_quo[DIV_W-1:16]) ? 16'hFFFF : w_quo[15:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded    <= 1'b0;
            r_filt_code <= '0;
            r_filt_pin  <= '0;
            r_filt_bat  <= '0;
        end else if (i_cmd.ema_en) begin
            r_loaded <= 1'b1;
            if (!r_loaded) begin
                r_filt_code <= r_code_mean;
                r_filt_pin  <= w_new_pin;
                r_filt_bat  <= r_bat_new;
            end else begin
                r_filt_code <= w_ema_code[11:0];
                r_filt_pin  <= w_ema_pin[11:0];
                r_filt_bat  <= w_ema_bat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_ld) begin
            r_out_data <= {r_filt_bat != 16'd0, charge_pct(r_filt_bat),
                           r_filt_bat, r_filt_pin, r_filt_code};
        end
    end

    assign o_sts.last_item = w_last;
    assign o_sts.div_done  = w_div_done;
    assign o_sts.out_free  = !r_out_valid || i_m_tready;
    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = r_out_data;

endmodule

// File: design/battery_voltage_monitor_unit.sv
// Battery voltage monitor top level: controller plus datapath.
// Depends on bvm_pkg, bvm_ctrl and bvm_datapath.
// Readings are taken one per cycle while a burst is collected; after its last item the two
// means are captured, then for the pin and the battery value a multiply and a pass of the
// serial divider, then the filter update, held while the previous result still waits on
// i_m_axis_tready, and the output load. No item is taken meanwhile. Reset (synchronous,
// active low) restores the registers, clears sums and filters.
module battery_voltage_monitor_unit #(
    parameter int SAMPLES  = 16,
    parameter int ADC_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // adc_code[11:0], adc_millivolts[23:12]
    input  logic [23:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // smoothed_code[11:0], smoothed_pin_mv[23:12], battery_mv[39:24],
    // charge_percent[46:40], reading_valid[47]
    output logic [47:0] o_m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import bvm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    bvm_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (w_sts),
        .o_cmd           (w_cmd)
    );

    bvm_datapath #(
        .SAMPLES  (SAMPLES),
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_tdata     (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tvalid  (o_m_axis_tvalid),
        .o_m_tdata   (o_m_axis_tdata)
    );

endmodule

// File: design/bvm_checker.sv
// Port-level checks of the battery voltage monitor, bound to the top level.
// Depends only on the top level's ports.
module bvm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output item changed while stalled");

    a_valid_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[47] == (o_m_axis_tdata[39:24] != 16'd0))
        else $error("reading_valid disagrees with battery_mv");

    a_charge_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[46:40] <= 7'd100
            && (o_m_axis_tdata[39:24] < 16'd4200 || o_m_axis_tdata[46:40] == 7'd100))
        else $error("charge_percent out of range");

    a_emit_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result issued while input side was ready");

endmodule

bind battery_voltage_monitor_unit bvm_checker u_bvm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
